@@ rtl/utd_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package utd_pkg;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NUL        = 2'd1,
        ST_INCOMPLETE = 2'd2,
        ST_INVALID    = 2'd3
    } status_t;

    localparam logic [20:0] CP_SUPP_BASE = 21'h10000;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
    localparam logic [5:0]  HI_SURR_TAG  = 6'b110110;
    localparam logic [5:0]  LO_SURR_TAG  = 6'b110111;
    localparam logic [7:0]  CONT_LO      = 8'h80;
    localparam logic [7:0]  CONT_HI      = 8'hBF;

    // one queue entry: what the back end has to emit for one input byte
    typedef struct packed {
        logic        pair;
        status_t     status;
        logic [15:0] unit_hi;
        logic [15:0] unit_lo;
    } cmd_t;

    // total sequence length for a lead byte, 0 if it cannot lead
    function automatic logic [2:0] seq_len(input logic [7:0] lead);
        logic [2:0] n;
        begin
            if (lead < 8'h80)
                n = 3'd1;
            else if (lead >= 8'hC2 && lead <= 8'hDF)
                n = 3'd2;
            else if (lead >= 8'hE0 && lead <= 8'hEF)
                n = 3'd3;
            else if (lead >= 8'hF0 && lead <= 8'hF4)
                n = 3'd4;
            else
                n = 3'd0;
            return n;
        end
    endfunction

    // legal continuation byte at position pos of a sequence led by lead
    function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                     input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        begin
            lo = CONT_LO;
            hi = CONT_HI;
            if (pos == 2'd1) begin
                if (lead == 8'hE0)
                    lo = 8'hA0;
                else if (lead == 8'hED)
                    hi = 8'h9F;
                else if (lead == 8'hF0)
                    lo = 8'h90;
                else if (lead == 8'hF4)
                    hi = 8'h8F;
            end
            return (b >= lo) && (b <= hi);
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/utd_front.sv @@
// Front end: accepts UTF-8 bytes, tracks the open sequence, classifies each byte.
// Produces one utd_pkg::cmd_t per byte into the queue.
`default_nettype none

module utd_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,
    input  wire logic          q_full,
    output logic               q_push,
    output utd_pkg::cmd_t      q_cmd
);

    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic [7:0]  held_reg [3];
    logic        hold_en;
    logic [2:0]  need;
    logic [2:0]  lead_len;
    logic [20:0] cp;
    logic [19:0] cp_off;
    logic        done;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign lead_len = utd_pkg::seq_len(s_tdata);
    assign need     = utd_pkg::seq_len(held_reg[0]);

    always_comb
    begin
        case (need)
            3'd2:    cp = {10'd0, held_reg[0][4:0], s_tdata[5:0]};
            3'd3:    cp = {5'd0, held_reg[0][3:0], held_reg[1][5:0], s_tdata[5:0]};
            3'd4:    cp = {held_reg[0][2:0], held_reg[1][5:0], held_reg[2][5:0],
                           s_tdata[5:0]};
            default: cp = '0;
        endcase
    end

    assign cp_off = 20'(cp - utd_pkg::CP_SUPP_BASE);

    always_comb
    begin
        cnt_next      = cnt_reg;
        hold_en       = 1'b0;
        done          = 1'b0;
        q_cmd.pair    = 1'b0;
        q_cmd.status  = utd_pkg::ST_INVALID;
        q_cmd.unit_hi = '0;
        q_cmd.unit_lo = '0;
        if (cnt_reg == 2'd0) begin
            if (s_tdata == 8'h00) begin
                q_cmd.status = utd_pkg::ST_NUL;
            end
            else if (lead_len == 3'd0) begin
                q_cmd.status = utd_pkg::ST_INVALID;
            end
            else if (lead_len == 3'd1) begin
                q_cmd.status  = utd_pkg::ST_OK;
                q_cmd.unit_hi = {8'd0, s_tdata};
            end
            else begin
                hold_en      = 1'b1;
                cnt_next     = 2'd1;
                q_cmd.status = utd_pkg::ST_INCOMPLETE;
            end
        end
        else if (need < 3'd2 || {1'b0, cnt_reg} >= need
                 || !utd_pkg::cont_ok(held_reg[0], cnt_reg, s_tdata)) begin
            cnt_next     = 2'd0;
            q_cmd.status = utd_pkg::ST_INVALID;
        end
        else if ({1'b0, cnt_reg} + 3'd1 < need) begin
            hold_en      = 1'b1;
            cnt_next     = 2'(cnt_reg + 2'd1);
            q_cmd.status = utd_pkg::ST_INCOMPLETE;
        end
        else begin
            done         = 1'b1;
            cnt_next     = 2'd0;
            q_cmd.status = utd_pkg::ST_OK;
        end
        if (done) begin
            if (|cp[20:16]) begin
                q_cmd.pair    = 1'b1;
                q_cmd.unit_hi = utd_pkg::HI_SURR_BASE + {6'd0, cp_off[19:10]};
                q_cmd.unit_lo = utd_pkg::LO_SURR_BASE + {6'd0, cp_off[9:0]};
            end
            else begin
                q_cmd.unit_hi = cp[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (q_push)
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_push && hold_en)
            held_reg[cnt_reg] <= s_tdata;
    end

endmodule

`default_nettype wire

@@ rtl/utd_fifo.sv @@
// Short queue of decoded commands between front and back end.
// Depends on utd_pkg for cmd_t.
`default_nettype none

module utd_fifo #(
    parameter int DEPTH = 4   // power of two, 2 or more
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire utd_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output utd_pkg::cmd_t      pop_data,
    output logic               not_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    utd_pkg::cmd_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

`default_nettype wire

@@ rtl/utd_back.sv @@
// Back end: pops commands and drives the UTF-16 result stream.
// A surrogate pair goes out as two transactions; depends on utd_pkg.
`default_nettype none

module utd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire utd_pkg::cmd_t q_cmd,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [15:0]        m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    logic        valid_reg;
    logic        pend_reg;
    logic [15:0] lo_reg;
    logic [15:0] unit_reg;
    logic [1:0]  status_reg;
    logic        last_reg;
    logic        out_free;

    assign out_free = !valid_reg || m_tready;
    assign q_pop    = out_free && !pend_reg && q_valid;
    assign m_tvalid = valid_reg;
    assign m_tdata  = unit_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (out_free) begin
            if (pend_reg) begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end
            else begin
                valid_reg <= q_valid;
                pend_reg  <= q_valid && q_cmd.pair;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free) begin
            if (pend_reg) begin
                unit_reg   <= lo_reg;
                status_reg <= utd_pkg::ST_OK;
                last_reg   <= 1'b1;
            end
            else if (q_valid) begin
                unit_reg   <= q_cmd.unit_hi;
                status_reg <= q_cmd.status;
                last_reg   <= !q_cmd.pair;
                lo_reg     <= q_cmd.unit_lo;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/utf8_to_utf16_decoder_top.sv @@
// Result path: each byte's command is registered in the command queue, then in the back end output register.
// Throughput: one byte per cycle unless the queue is full; a surrogate pair goes out as
// two transactions, the command queue (FIFO_DEPTH entries) absorbs that while the front takes bytes.
// Reset: asynchronous, clears the held-byte count, queue pointers and output valid.
// Top level of the UTF-8 to UTF-16 decoder: front end, command queue, back end.
`default_nettype none

module utf8_to_utf16_decoder_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] in_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,    // [15:0] code_unit
    output logic [1:0]       m_tuser,    // [1:0] status
    output logic             m_tlast
);

    utd_pkg::cmd_t push_cmd;
    utd_pkg::cmd_t pop_cmd;
    logic          push;
    logic          full;
    logic          pop;
    logic          not_empty;

    utd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (full),
        .q_push   (push),
        .q_cmd    (push_cmd)
    );

    utd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .not_empty (not_empty)
    );

    utd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (not_empty),
        .q_cmd    (pop_cmd),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/utd_checker.sv @@
// Port-level assertions for utf8_to_utf16_decoder_top, attached by bind.
// Depends on utd_pkg for status codes.
`default_nettype none

module utd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    a_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != utd_pkg::ST_OK |-> m_tdata == 16'd0)
        else $error("non-ok status with nonzero code unit");

    a_first_is_high: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser == utd_pkg::ST_OK
                                && m_tdata[15:10] == utd_pkg::HI_SURR_TAG)
        else $error("non-last transaction is not a high surrogate");

    a_low_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast
                                            && m_tdata[15:10] == utd_pkg::LO_SURR_TAG)
        else $error("high surrogate not followed by low surrogate");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled output changed");

endmodule

bind utf8_to_utf16_decoder_top utd_checker u_utd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ tb/utf8_to_utf16_decoder_top_tb.sv @@
// Self-checking testbench for utf8_to_utf16_decoder_top: drives UTF-8 bytes on the
// s_ stream, predicts the UTF-16 units and status, and checks every m_ transaction.
// Depends on rtl/utd_pkg.sv (status codes, surrogate constants) and the DUT.
`timescale 1ns / 100ps

class utf16_transcode_board;
    typedef struct {
        logic [15:0]      unit;
        utd_pkg::status_t status;
        logic             last;
    } unit_rec_t;

    logic [7:0]  held[3];
    logic [1:0]  held_cnt;
    unit_rec_t   expected_units[$];
    int          mismatches;

    function new();
        held_cnt   = 2'd0;
        mismatches = 0;
    endfunction

    function int unsigned lead_len(logic [7:0] b);
        if (b < 8'h80)
            return 1;
        if (b >= 8'hC2 && b <= 8'hDF)
            return 2;
        if (b >= 8'hE0 && b <= 8'hEF)
            return 3;
        if (b >= 8'hF0 && b <= 8'hF4)
            return 4;
        return 0;
    endfunction

    // second byte of E0/ED/F0/F4 has a narrowed range
    function bit cont_legal(logic [7:0] lead, logic [1:0] pos, logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        if (pos == 2'd1) begin
            if (lead == 8'hE0)
                lo = 8'hA0;
            else if (lead == 8'hED)
                hi = 8'h9F;
            else if (lead == 8'hF0)
                lo = 8'h90;
            else if (lead == 8'hF4)
                hi = 8'h8F;
        end
        return (b >= lo) && (b <= hi);
    endfunction

    function void queue_unit(logic [15:0] unit, utd_pkg::status_t st, logic last);
        unit_rec_t rec;
        rec.unit   = unit;
        rec.status = st;
        rec.last   = last;
        expected_units.push_back(rec);
    endfunction

    function void predict_units(logic [7:0] b);
        int unsigned need;
        logic [20:0] cp;
        logic [20:0] off;
        if (held_cnt == 2'd0) begin
            need = lead_len(b);
            if (b == 8'h00)
                queue_unit(16'h0000, utd_pkg::ST_NUL, 1'b1);
            else if (need == 0)
                queue_unit(16'h0000, utd_pkg::ST_INVALID, 1'b1);
            else if (need == 1)
                queue_unit({8'h00, b}, utd_pkg::ST_OK, 1'b1);
            else begin
                held[0]  = b;
                held_cnt = 2'd1;
                queue_unit(16'h0000, utd_pkg::ST_INCOMPLETE, 1'b1);
            end
            return;
        end
        need = lead_len(held[0]);
        if (need < 2 || held_cnt >= need || !cont_legal(held[0], held_cnt, b)) begin
            held_cnt = 2'd0;
            queue_unit(16'h0000, utd_pkg::ST_INVALID, 1'b1);
            return;
        end
        if (held_cnt + 1 < need) begin
            held[held_cnt] = b;
            held_cnt       = held_cnt + 2'd1;
            queue_unit(16'h0000, utd_pkg::ST_INCOMPLETE, 1'b1);
            return;
        end
        case (need)
            2:       cp = {10'd0, held[0][4:0], b[5:0]};
            3:       cp = {5'd0, held[0][3:0], held[1][5:0], b[5:0]};
            default: cp = {held[0][2:0], held[1][5:0], held[2][5:0], b[5:0]};
        endcase
        held_cnt = 2'd0;
        if (cp < utd_pkg::CP_SUPP_BASE)
            queue_unit(cp[15:0], utd_pkg::ST_OK, 1'b1);
        else begin
            off = cp - utd_pkg::CP_SUPP_BASE;
            queue_unit(utd_pkg::HI_SURR_BASE + {6'd0, off[19:10]}, utd_pkg::ST_OK, 1'b0);
            queue_unit(utd_pkg::LO_SURR_BASE + {6'd0, off[9:0]}, utd_pkg::ST_OK, 1'b1);
        end
    endfunction

    task report(string msg);
        mismatches++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task match_unit(logic [15:0] unit, logic [1:0] st, logic last);
        unit_rec_t want;
        if (expected_units.size() == 0) begin
            report($sformatf("unexpected unit %h status %0d last %b", unit, st, last));
            return;
        end
        want = expected_units.pop_front();
        if (unit !== want.unit)
            report($sformatf("code_unit %h, expected %h", unit, want.unit));
        if (st !== want.status)
            report($sformatf("status %0d, expected %0d", st, want.status));
        if (last !== want.last)
            report($sformatf("last %b, expected %b", last, want.last));
    endtask
endclass

module utf8_to_utf16_decoder_top_tb;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int LONG_HOLD     = 200;
    localparam int RANDOM_BYTES  = 600;
    localparam int PHASE_BYTES   = 100;
    localparam int DIRECTED_LEN  = 25;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    utf16_transcode_board board;
    int  tx_gap_pct;
    int  rx_stall_pct;
    bit  long_hold_req;
    int  bytes_sent;
    int  cycle_cnt = 0;

    utf8_to_utf16_decoder_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(30, 8);
        return $urandom_range(3, 1);
    endfunction

    function automatic logic [20:0] pick_code_point();
        logic [20:0] cp;
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(7))
                0:       cp = 21'h00080;
                1:       cp = 21'h007FF;
                2:       cp = 21'h00800;
                3:       cp = 21'h0D7FF;
                4:       cp = 21'h0E000;
                5:       cp = 21'h0FFFF;
                6:       cp = 21'h10000;
                default: cp = 21'h10FFFF;
            endcase
            return cp;
        end
        case ($urandom_range(3))
            0:       cp = 21'($urandom_range(21'h7F, 21'h1));
            1:       cp = 21'($urandom_range(21'h7FF, 21'h80));
            2:
            begin
                cp = 21'($urandom_range(21'hFFFF, 21'h800));
                if (cp >= 21'hD800 && cp <= 21'hDFFF)
                    cp = cp ^ 21'h4000;
            end
            default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
        endcase
        return cp;
    endfunction

    // called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(tx_gap_pct);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_code_point(input logic [20:0] cp, input bit truncate);
        logic [7:0] seq_bytes[$];
        if (cp < 21'h80)
            seq_bytes.push_back(cp[7:0]);
        else if (cp < 21'h800) begin
            seq_bytes.push_back({3'b110, cp[10:6]});
            seq_bytes.push_back({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000) begin
            seq_bytes.push_back({4'b1110, cp[15:12]});
            seq_bytes.push_back({2'b10, cp[11:6]});
            seq_bytes.push_back({2'b10, cp[5:0]});
        end
        else begin
            seq_bytes.push_back({5'b11110, cp[20:18]});
            seq_bytes.push_back({2'b10, cp[17:12]});
            seq_bytes.push_back({2'b10, cp[11:6]});
            seq_bytes.push_back({2'b10, cp[5:0]});
        end
        if (truncate && seq_bytes.size() > 1)
            void'(seq_bytes.pop_back());
        foreach (seq_bytes[i])
            send_byte(seq_bytes[i]);
    endtask

    // receiver: random stalls plus one long hold-off on request
    initial
    begin
        int stall;
        m_tready = 1'b0;
        stall    = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall         = LONG_HOLD;
            end
            if (stall > 0) begin
                m_tready = 1'b0;
                stall--;
            end
            else if (!rst_n)
                m_tready = 1'b0;
            else begin
                stall    = pick_gap(rx_stall_pct);
                m_tready = (stall == 0);
                if (stall > 0)
                    stall--;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("** utf8_to_utf16_decoder_top: FAILED **");
            $finish;
        end
        if (rst_n) begin
            if (s_tvalid && s_tready)
                board.predict_units(s_tdata);
            if (m_tvalid && m_tready)
                board.match_unit(m_tdata, m_tuser, m_tlast);
        end
    end

    initial
    begin
        logic [7:0] directed[DIRECTED_LEN];
        int  target;
        int  next_phase;
        int  roll;
        bit  pressure_done;
        board         = new();
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        tx_gap_pct    = 20;
        rx_stall_pct  = 20;
        long_hold_req = 1'b0;
        bytes_sent    = 0;
        pressure_done = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // NUL, ASCII top, bad leads, edge code points, bad continuations, NUL mid-sequence
        directed = '{8'h00, 8'h7F, 8'h80, 8'hFF,
                     8'hC2, 8'h80,
                     8'hEF, 8'hBF, 8'hBF,
                     8'hF0, 8'h90, 8'h80, 8'h80,
                     8'hF4, 8'h8F, 8'hBF, 8'hBF,
                     8'hE0, 8'h9F,
                     8'hED, 8'hA0,
                     8'hC2, 8'h00,
                     8'hF4, 8'h90};
        foreach (directed[i])
            send_byte(directed[i]);

        target       = bytes_sent + RANDOM_BYTES;
        next_phase   = bytes_sent + PHASE_BYTES;
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        while (bytes_sent < target)
        begin
            if (bytes_sent >= next_phase) begin
                next_phase   = next_phase + PHASE_BYTES;
                tx_gap_pct   = ($urandom_range(2) == 0) ? 0 : $urandom_range(60, 10);
                rx_stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(60, 10);
                if (!pressure_done && bytes_sent >= target - RANDOM_BYTES / 2) begin
                    tx_gap_pct    = 0;
                    long_hold_req = 1'b1;
                    pressure_done = 1'b1;
                end
            end
            roll = $urandom_range(99);
            if (roll < 75)
                send_code_point(pick_code_point(), 1'b0);
            else if (roll < 87)
                send_code_point(pick_code_point(), 1'b1);
            else
                send_byte(8'($urandom_range(255)));
        end
        s_tvalid = 1'b0;

        while (board.expected_units.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.mismatches == 0 && board.expected_units.size() == 0)
            $display("** utf8_to_utf16_decoder_top: PASSED **");
        else
            $display("** utf8_to_utf16_decoder_top: FAILED **");
        $finish;
    end

endmodule
